[rtl/led_matrix_column_scanner_assert.svh]
// assertion macros for the led matrix column scanner
// expects clk and rst_n in the scope where the macros are used
`ifndef LED_MATRIX_COLUMN_SCANNER_ASSERT_SVH
`define LED_MATRIX_COLUMN_SCANNER_ASSERT_SVH

// property that must hold at every edge out of reset
`define LMCS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent now implies consequent in the next cycle
`define LMCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lmcs_pkg.sv]
// shared constants and types for the led matrix column scanner
// no dependencies
package lmcs_pkg;

    localparam int COLUMNS     = 10;
    localparam int SELECT_BITS = 16;
    localparam int ROW_BITS    = 20;
    localparam int PAD_BITS    = 4;

    localparam int DRIVER_BITS = 1 + 32 + PAD_BITS;
    localparam int COLUMN_W    = 4;
    localparam int PERIOD_W    = 16;
    localparam int BIT_W       = 6;
    localparam int POS_W       = 6;
    localparam int ROW_IDX_W   = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;
    localparam int SEL_IDX_W   = $clog2(SELECT_BITS);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2000;

    typedef enum logic [2:0] {
        SEG_IDLE   = 3'd0,
        SEG_BLANK  = 3'd1,
        SEG_BLATCH = 3'd2,
        SEG_DRIVER = 3'd3,
        SEG_SELECT = 3'd4,
        SEG_SLATCH = 3'd5,
        SEG_FINAL  = 3'd6,
        SEG_FLATCH = 3'd7
    } segment_t;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

endpackage

[rtl/led_matrix_column_scanner.sv]
// Column scanner for a multiplexed LED matrix: one item in, one item out, every clock
// cycle while the output side takes items. A write item stores a column word in a
// 10-entry synchronous frame memory; a tick item moves the refresh timer and the pin
// sequencer one step. The result item holds the pin levels after the item, taken
// straight from the pin registers, so the input is held only while a result waits
// under stall. The frame memory is read once per column, on the tick that ends the
// blanking latch; its registered read data serves the row driver bits from then on.
// Depends on lmcs_pkg and led_matrix_column_scanner_assert.svh.
module led_matrix_column_scanner (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lmcs_pkg::PERIOD_W-1:0] refresh_period,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [lmcs_pkg::COLUMN_W-1:0] column,
    input  logic [lmcs_pkg::ROW_BITS-1:0] pixels,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          select_data,
    output logic                          select_clock,
    output logic                          select_latch,
    output logic                          driver_data,
    output logic                          driver_clock,
    output logic                          busy_res
);
    import lmcs_pkg::*;

    // frame memory and its read port
    logic [ROW_BITS-1:0] frame_mem [COLUMNS];
    logic [COLUMNS-1:0]  written_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic                rd_en;

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] count_reg, count_next;
    logic                due_reg, due_next;
    logic [COLUMN_W-1:0] col_reg, col_next;
    segment_t            seg_reg, seg_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                phase_reg, phase_next;

    logic sd_reg, sd_next;
    logic sc_reg, sc_next;
    logic sl_reg, sl_next;
    logic dd_reg, dd_next;
    logic dc_reg, dc_next;
    logic busy_reg, busy_next;
    logic out_valid_reg;

    logic                in_acc;
    logic                step;
    logic                wr_en;
    logic [PERIOD_W-1:0] count_inc;
    logic [PERIOD_W-1:0] period_eff;
    logic                due_mid;
    logic                start;
    segment_t            seg_mid;
    logic [COLUMN_W-1:0] col_mid;
    logic [BIT_W-1:0]    bit_mid;
    logic                phase_mid;
    logic                do_step;
    logic [BIT_W-1:0]    bit_inc;
    logic [BIT_W-1:0]    seg_count;
    logic                finish;
    logic [COLUMN_W-1:0] col_inc;
    logic [ROW_BITS-1:0] drv_word;
    logic [BIT_W:0]      drv_idx;
    logic [BIT_W:0]      sel_idx;
    logic [POS_W-1:0]    sel_pos;
    logic                drv_bit;
    logic                sel_bit;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_acc    = in_valid && !in_stall;
    assign step      = in_acc && (kind == KIND_TICK);
    assign wr_en     = in_acc && (kind == KIND_WRITE) && ({1'b0, column} < (COLUMN_W+1)'(COLUMNS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            period_reg <= refresh_period;
        end
    end

    // frame memory: one write port for write items, one read for the sequencer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[column] <= pixels;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[col_mid];
        end
    end

    // a read and a write never share a cycle, so earlier writes are always seen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[column] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= written_reg[col_mid];
            end
        end
    end

    assign drv_word = rd_valid_reg ? rd_data_reg : '0;

    // refresh timer and frame start
    always_comb
    begin
        count_inc  = count_reg + 1'b1;
        period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        count_next = count_reg;
        due_mid    = due_reg;
        if (step)
        begin
            count_next = count_inc;
            if (count_inc >= period_eff)
            begin
                count_next = '0;
                due_mid    = 1'b1;
            end
        end
        start     = step && (seg_reg == SEG_IDLE) && due_mid;
        due_next  = start ? 1'b0 : due_mid;
        seg_mid   = start ? SEG_BLANK : seg_reg;
        col_mid   = start ? '0 : col_reg;
        bit_mid   = start ? '0 : bit_reg;
        phase_mid = start ? 1'b0 : phase_reg;
        do_step   = step && (seg_mid != SEG_IDLE);
    end

    // sequencer next state
    always_comb
    begin
        bit_inc    = bit_mid + 1'b1;
        col_inc    = col_mid + 1'b1;
        seg_count  = (seg_mid == SEG_DRIVER) ? BIT_W'(DRIVER_BITS) : BIT_W'(SELECT_BITS);
        finish     = 1'b0;
        rd_en      = 1'b0;
        seg_next   = seg_mid;
        col_next   = col_mid;
        bit_next   = bit_mid;
        phase_next = phase_mid;
        if (do_step)
        begin
            case (seg_mid)
                SEG_BLANK, SEG_FINAL, SEG_DRIVER, SEG_SELECT:
                begin
                    if (!phase_mid)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        bit_next   = bit_inc;
                        finish     = (bit_inc >= seg_count);
                    end
                end
                default:
                begin
                    phase_next = !phase_mid;
                    finish     = phase_mid;
                end
            endcase
            if (finish)
            begin
                bit_next   = '0;
                phase_next = 1'b0;
                case (seg_mid)
                    SEG_BLANK:  seg_next = SEG_BLATCH;
                    SEG_BLATCH:
                    begin
                        seg_next = SEG_DRIVER;
                        rd_en    = 1'b1;
                    end
                    SEG_DRIVER: seg_next = SEG_SELECT;
                    SEG_SELECT: seg_next = SEG_SLATCH;
                    SEG_SLATCH:
                    begin
                        col_next = col_inc;
                        seg_next = ({1'b0, col_inc} < (COLUMN_W+1)'(COLUMNS)) ? SEG_BLANK
                                                                               : SEG_FINAL;
                    end
                    SEG_FINAL:  seg_next = SEG_FLATCH;
                    default:
                    begin
                        col_next = '0;
                        seg_next = SEG_IDLE;
                    end
                endcase
            end
        end
    end

    // serial bit values for the current pin step
    always_comb
    begin
        drv_idx = (BIT_W+1)'(ROW_BITS) - {1'b0, bit_mid};
        sel_idx = (BIT_W+1)'(SELECT_BITS - 1) - {1'b0, bit_mid};
        sel_pos = ({1'b0, col_mid} < 5'd5) ? POS_W'(col_mid) + POS_W'(1)
                                           : POS_W'(col_mid) + POS_W'(4);
        if (bit_mid == '0)
        begin
            drv_bit = 1'b1;
        end
        else if (bit_mid <= BIT_W'(ROW_BITS))
        begin
            drv_bit = drv_word[drv_idx[ROW_IDX_W-1:0]];
        end
        else
        begin
            drv_bit = 1'b0;
        end
        // active-low select: only the column's own position is zero
        sel_bit = (bit_mid < BIT_W'(SELECT_BITS))
                  && ((BIT_W+1)'(sel_pos) != {1'b0, sel_idx[BIT_W-1:0]});
    end

    // pin levels
    always_comb
    begin
        sd_next   = sd_reg;
        sc_next   = sc_reg;
        sl_next   = sl_reg;
        dd_next   = dd_reg;
        dc_next   = dc_reg;
        busy_next = busy_reg;
        if (in_acc)
        begin
            busy_next = (kind == KIND_TICK) ? (seg_mid != SEG_IDLE) : (seg_reg != SEG_IDLE);
        end
        if (do_step)
        begin
            case (seg_mid)
                SEG_BLANK, SEG_FINAL, SEG_SELECT:
                begin
                    if (!phase_mid)
                    begin
                        sd_next = (seg_mid == SEG_SELECT) ? sel_bit : 1'b1;
                        sc_next = 1'b1;
                    end
                    else
                    begin
                        sc_next = 1'b0;
                    end
                end
                SEG_DRIVER:
                begin
                    if (!phase_mid)
                    begin
                        dd_next = drv_bit;
                        dc_next = 1'b1;
                    end
                    else
                    begin
                        dc_next = 1'b0;
                    end
                end
                default:
                begin
                    sl_next = !phase_mid;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            due_reg       <= 1'b0;
            col_reg       <= '0;
            seg_reg       <= SEG_IDLE;
            bit_reg       <= '0;
            phase_reg     <= 1'b0;
            sd_reg        <= 1'b0;
            sc_reg        <= 1'b0;
            sl_reg        <= 1'b0;
            dd_reg        <= 1'b0;
            dc_reg        <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            due_reg       <= due_next;
            col_reg       <= col_next;
            seg_reg       <= seg_next;
            bit_reg       <= bit_next;
            phase_reg     <= phase_next;
            sd_reg        <= sd_next;
            sc_reg        <= sc_next;
            sl_reg        <= sl_next;
            dd_reg        <= dd_next;
            dc_reg        <= dc_next;
            busy_reg      <= busy_next;
            if (in_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign select_data  = sd_reg;
    assign select_clock = sc_reg;
    assign select_latch = sl_reg;
    assign driver_data  = dd_reg;
    assign driver_clock = dc_reg;
    assign busy_res     = busy_reg;

`include "led_matrix_column_scanner_assert.svh"

    `LMCS_ASSERT_ALWAYS(a_one_clock_high, !(sc_reg && dc_reg) && !(sl_reg && (sc_reg || dc_reg)), "two serial strobes high at once")
    `LMCS_ASSERT_ALWAYS(a_idle_clean, (seg_reg != SEG_IDLE) || (!phase_reg && (bit_reg == '0) && (col_reg == '0)), "sequencer idle with stale counters")
    `LMCS_ASSERT_NEXT(a_read_enters_driver, rd_en, (seg_reg == SEG_DRIVER) && (bit_reg == '0), "frame read without entering driver part")

endmodule

[test/tb_top.sv]
// self-checking bench for led_matrix_column_scanner: queued write and tick items,
// an item-level model of the pin sequencer, random idling on both sides
// depends on lmcs_pkg and the scanner rtl
`timescale 1ns / 100ps

module tb_top;
    import lmcs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        kind_t                kind;
        logic [COLUMN_W-1:0]  column;
        logic [ROW_BITS-1:0]  pixels;
    } scan_cmd_t;

    typedef struct packed {
        logic sel_data;
        logic sel_clock;
        logic sel_latch;
        logic drv_data;
        logic drv_clock;
        logic busy;
    } pins_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [PERIOD_W-1:0]   refresh_period = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  kind = KIND_WRITE;
    logic [COLUMN_W-1:0]   column = '0;
    logic [ROW_BITS-1:0]   pixels = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  select_data;
    logic                  select_clock;
    logic                  select_latch;
    logic                  driver_data;
    logic                  driver_clock;
    logic                  busy_res;

    scan_cmd_t cmd_q[$];
    pins_t     pending_pins[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        steady = 1'b0;

    // scanner model state
    logic [ROW_BITS-1:0]    frame_mem[COLUMNS] = '{default: '0};
    logic [PERIOD_W-1:0]    period_set = PERIOD_RESET;
    logic [PERIOD_W-1:0]    tick_count = '0;
    bit                     due = 1'b0;
    logic [COLUMN_W-1:0]    col_ptr = '0;
    segment_t               seg = SEG_IDLE;
    logic [BIT_W-1:0]       bit_pos = '0;
    bit                     phase = 1'b0;
    logic [DRIVER_BITS-1:0] shift_word = '0;
    pins_t                  pins = '0;

    led_matrix_column_scanner u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .refresh_period (refresh_period),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .column       (column),
        .pixels       (pixels),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .select_data  (select_data),
        .select_clock (select_clock),
        .select_latch (select_latch),
        .driver_data  (driver_data),
        .driver_clock (driver_clock),
        .busy_res     (busy_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [SELECT_BITS-1:0] column_select_word(input logic [COLUMN_W-1:0] c);
        logic [SELECT_BITS-1:0] w;
        int pos;
        w = '1;
        pos = (int'(c) < 5) ? int'(c) + 1 : int'(c) + 4;
        if (pos < SELECT_BITS && pos < 32)
            w[pos] = 1'b0;
        return w;
    endfunction

    function automatic void enter_segment(input segment_t s);
        seg = s;
        bit_pos = '0;
        phase = 1'b0;
    endfunction

    function automatic void end_segment();
        case (seg)
            SEG_BLANK:  enter_segment(SEG_BLATCH);
            SEG_BLATCH:
            begin
                shift_word = (col_ptr < COLUMNS) ? DRIVER_BITS'(frame_mem[col_ptr]) : '0;
                enter_segment(SEG_DRIVER);
            end
            SEG_DRIVER:
            begin
                shift_word = DRIVER_BITS'(column_select_word(col_ptr));
                enter_segment(SEG_SELECT);
            end
            SEG_SELECT: enter_segment(SEG_SLATCH);
            SEG_SLATCH:
            begin
                col_ptr = col_ptr + 1'b1;
                if (col_ptr < COLUMNS)
                    enter_segment(SEG_BLANK);
                else
                    enter_segment(SEG_FINAL);
            end
            SEG_FINAL:  enter_segment(SEG_FLATCH);
            default:
            begin
                col_ptr = '0;
                enter_segment(SEG_IDLE);
            end
        endcase
    endfunction

    // data with clock high, then clock low and on to the next bit
    function automatic void shift_out(input bit to_driver, input logic b, input int count);
        if (!phase)
        begin
            if (to_driver)
            begin
                pins.drv_data = b;
                pins.drv_clock = 1'b1;
            end
            else
            begin
                pins.sel_data = b;
                pins.sel_clock = 1'b1;
            end
            phase = 1'b1;
        end
        else
        begin
            if (to_driver)
                pins.drv_clock = 1'b0;
            else
                pins.sel_clock = 1'b0;
            phase = 1'b0;
            bit_pos = bit_pos + 1'b1;
            if (int'(bit_pos) >= count)
                end_segment();
        end
    endfunction

    function automatic void pin_step();
        int p;
        logic b;
        p = int'(bit_pos);
        case (seg)
            SEG_BLANK, SEG_FINAL: shift_out(1'b0, 1'b1, SELECT_BITS);
            SEG_DRIVER:
            begin
                if (p == 0)
                    b = 1'b1;
                else if (p <= ROW_BITS)
                    b = shift_word[ROW_BITS - p];
                else
                    b = 1'b0;
                shift_out(1'b1, b, DRIVER_BITS);
            end
            SEG_SELECT:
            begin
                b = (p < SELECT_BITS) ? shift_word[SELECT_BITS - 1 - p] : 1'b0;
                shift_out(1'b0, b, SELECT_BITS);
            end
            default:
            begin
                pins.sel_latch = !phase;
                if (!phase)
                    phase = 1'b1;
                else
                begin
                    phase = 1'b0;
                    end_segment();
                end
            end
        endcase
    endfunction

    function automatic pins_t step_scanner(input kind_t k, input logic [COLUMN_W-1:0] c,
                                           input logic [ROW_BITS-1:0] pix);
        int per;
        pins_t res;
        bit running;
        if (k == KIND_WRITE)
        begin
            if (c < COLUMNS)
                frame_mem[c] = pix;
            running = (seg != SEG_IDLE);
        end
        else
        begin
            // a zero period behaves like one
            per = (period_set == 0) ? 1 : int'(period_set);
            tick_count = tick_count + 1'b1;
            if (int'(tick_count) >= per)
            begin
                tick_count = '0;
                due = 1'b1;
            end
            if (seg == SEG_IDLE && due)
            begin
                due = 1'b0;
                col_ptr = '0;
                if (COLUMNS > 0)
                    enter_segment(SEG_BLANK);
                else
                    enter_segment(SEG_FINAL);
            end
            running = (seg != SEG_IDLE);
            if (running)
                pin_step();
        end
        res = pins;
        res.busy = running;
        return res;
    endfunction

    function automatic void check_pin(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endfunction

    // sender: predicts each accepted item, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin : feed
        scan_cmd_t cmd;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                pending_pins.push_back(step_scanner(kind_t'(kind), column, pixels));
            if (!in_valid || !in_stall)
            begin
                if (cmd_q.size() != 0 && (steady || $urandom_range(99) >= 14))
                begin
                    cmd = cmd_q.pop_front();
                    in_valid <= 1'b1;
                    kind <= cmd.kind;
                    column <= cmd.column;
                    pixels <= cmd.pixels;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch
        pins_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_pins.size() == 0)
                begin
                    $error("result item with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = pending_pins.pop_front();
                    check_pin("select_data", want.sel_data, select_data);
                    check_pin("select_clock", want.sel_clock, select_clock);
                    check_pin("select_latch", want.sel_latch, select_latch);
                    check_pin("driver_data", want.drv_data, driver_data);
                    check_pin("driver_clock", want.drv_clock, driver_clock);
                    check_pin("busy_res", want.busy, busy_res);
                end
            end
            out_stall <= !steady && ($urandom_range(99) < 14);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_cmd(input kind_t k, input int c, input logic [ROW_BITS-1:0] pix);
        scan_cmd_t cmd;
        cmd.kind = k;
        cmd.column = COLUMN_W'(c);
        cmd.pixels = pix;
        cmd_q.push_back(cmd);
    endtask

    // mostly ticks so frames run through, with column writes landing anywhere in them
    task automatic add_random(input int count, input int tick_pct);
        int c;
        logic [ROW_BITS-1:0] pix;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < tick_pct)
                add_cmd(KIND_TICK, $urandom_range(15), ROW_BITS'($urandom));
            else
            begin
                c = ($urandom_range(9) < 8) ? $urandom_range(COLUMNS - 1) : $urandom_range(15);
                case ($urandom_range(7))
                    0: pix = '0;
                    1: pix = '1;
                    default: pix = ROW_BITS'($urandom);
                endcase
                add_cmd(KIND_WRITE, c, pix);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_q.size() != 0 || in_valid || pending_pins.size() != 0);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        refresh_period <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        period_set = value;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset period, column extremes, columns past the end, pixel extremes
        add_cmd(KIND_WRITE, 0, '1);
        add_cmd(KIND_WRITE, COLUMNS - 1, 20'h80001);
        add_cmd(KIND_WRITE, 4, '0);
        add_cmd(KIND_WRITE, 5, 20'h55555);
        add_cmd(KIND_WRITE, 1, 20'hAAAAA);
        add_cmd(KIND_WRITE, COLUMNS, '1);
        add_cmd(KIND_WRITE, 15, 20'h12345);
        add_cmd(KIND_TICK, 0, '0);
        add_cmd(KIND_TICK, 15, '1);
        add_cmd(KIND_TICK, 3, 20'hFFFF0);
        wait_drained();

        // zero period: frame starts at once, writes land during the frame
        write_period('0);
        @(negedge clk);
        add_cmd(KIND_TICK, 0, '0);
        add_cmd(KIND_WRITE, 0, 20'h0F0F0);
        add_cmd(KIND_TICK, 0, '0);
        add_cmd(KIND_WRITE, 12, 20'hFFFFF);
        add_cmd(KIND_TICK, 0, '0);
        add_random(160, 88);
        wait_drained();
        add_random(160, 88);
        wait_drained();

        // shortest period, no idling on either side, a due stays pending through each frame
        write_period(16'd1);
        @(negedge clk);
        steady = 1'b1;
        add_random(150, 85);
        wait_drained();
        steady = 1'b0;

        write_period('1);
        @(negedge clk);
        add_random(60, 80);
        wait_drained();

        // a period just longer than one frame
        write_period(PERIOD_W'($urandom_range(1456, 1520)));
        @(negedge clk);
        add_random(60, 92);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_pins.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[led_matrix_column_scanner.f]
+incdir+rtl
rtl/lmcs_pkg.sv
rtl/led_matrix_column_scanner.sv
test/tb_top.sv
